// ===== src/ipv4_longest_prefix_lookup_defines.svh =====
// Assertion macros shared by the route lookup RTL.
`ifndef IPV4_LONGEST_PREFIX_LOOKUP_DEFINES_SVH
`define IPV4_LONGEST_PREFIX_LOOKUP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ILPL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ILPL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ilpl_pkg.sv =====
`timescale 1ns / 1ps

package ilpl_pkg;

    localparam int ADDR_W         = 32;
    localparam int LEN_W          = 6;
    localparam int REGION_W       = 32;
    localparam int STATUS_W       = 2;
    localparam int MIN_LOOKUP_LEN = 7;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    localparam logic [STATUS_W-1:0] ST_STORED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SKIPPED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0]   key;
        logic [LEN_W-1:0]    len;
        logic [REGION_W-1:0] region;
    } t_route;

    typedef struct packed {
        logic key_match;    // masked target equals stored key
        logic take_lookup;  // entry is the best lookup match so far
    } t_cmp_res;

    // Netmask for a prefix length; lengths above 32 saturate to all ones.
    function automatic logic [ADDR_W-1:0] net_mask(input logic [LEN_W-1:0] len);
        logic [ADDR_W-1:0] mask;
        if (len == '0) begin
            mask = '0;
        end else if (len >= LEN_W'(ADDR_W)) begin
            mask = '1;
        end else begin
            mask = {ADDR_W{1'b1}} << (LEN_W'(ADDR_W) - len);
        end
        return mask;
    endfunction

endpackage

// ===== src/ilpl_route_mem.sv =====
`timescale 1ns / 1ps

module ilpl_route_mem #(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [IDX_W-1:0]     i_wr_idx,
    input  ilpl_pkg::t_route     i_wr_data,
    input  logic                 i_rd_en,
    input  logic [IDX_W-1:0]     i_rd_idx,
    output ilpl_pkg::t_route     o_rd_data
);

    ilpl_pkg::t_route r_mem [DEPTH];
    ilpl_pkg::t_route r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/ilpl_match_unit.sv =====
`timescale 1ns / 1ps

module ilpl_match_unit (
    input  logic                             i_is_lookup,
    input  logic [ilpl_pkg::ADDR_W-1:0]      i_target,
    input  ilpl_pkg::t_route                 i_entry,
    input  logic                             i_have_hit,
    input  logic [ilpl_pkg::LEN_W-1:0]       i_best_len,
    output ilpl_pkg::t_cmp_res               o_res
);

    logic [ilpl_pkg::ADDR_W-1:0] masked;
    logic                        len_ok;

    always_comb begin
        // Lookups mask the target by the entry length; inserts hold a pre-masked key.
        masked = i_is_lookup ? (i_target & ilpl_pkg::net_mask(i_entry.len)) : i_target;
        len_ok = i_entry.len inside {[ilpl_pkg::MIN_LOOKUP_LEN:ilpl_pkg::ADDR_W]};
        o_res.key_match   = (masked == i_entry.key);
        o_res.take_lookup = i_is_lookup && len_ok && o_res.key_match
                            && (!i_have_hit || (i_entry.len > i_best_len));
    end

endmodule

// ===== src/ipv4_longest_prefix_lookup.sv =====
`timescale 1ns / 1ps

// IPv4 longest-prefix route table. Raise start while busy is low to issue one
// request: an insert (req_type 0) or a lookup (req_type 1). Every request gives
// exactly one result, shown for a single cycle with o_result_valid high; the
// receiver cannot stall it, so capture it on that cycle. Timing: one route
// memory read port feeds one shared comparator, which walks the filled entries
// one per cycle. With at least one route filled, a request walks every filled
// entry in the scan state, then passes the last-compare and finish states;
// on an empty table it goes straight to the finish state, and an insert of
// address zero is answered on the next cycle. Busy stays high for the whole
// walk and drops as the result strobe rises, so the next request can be taken
// at the edge that ends the strobe. Routes are never removed, so filled
// entries always form slots 0..count-1 and a fill count replaces per-entry
// valid bits: no clearing pass runs after reset.
// Results: insert gives o_insert_status (0 stored, 1 skipped, 2 table full)
// with o_found_id 0 and o_hit 0; lookup gives the region of the longest route
// of length 7 to 32 that matches, or 0 with o_hit low, and status 0.

`include "ipv4_longest_prefix_lookup_defines.svh"

module ipv4_longest_prefix_lookup #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_req_type,
    input  logic [ilpl_pkg::ADDR_W-1:0]         i_address,
    input  logic [ilpl_pkg::LEN_W-1:0]          i_prefix_len,
    input  logic [ilpl_pkg::REGION_W-1:0]       i_region_id,
    output logic                                o_result_valid,
    output logic [ilpl_pkg::REGION_W-1:0]       o_found_id,
    output logic                                o_hit,
    output logic [ilpl_pkg::STATUS_W-1:0]       o_insert_status
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(TABLE_ENTRIES);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_LAST   = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state                          r_state, n_state;
    logic [CNT_W-1:0]                r_count, n_count;
    logic [IDX_W-1:0]                r_rd_idx, n_rd_idx;
    logic                            r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0]                r_cmp_idx, n_cmp_idx;
    logic                            r_is_lookup, n_is_lookup;
    logic [ilpl_pkg::ADDR_W-1:0]     r_target, n_target;
    logic [ilpl_pkg::LEN_W-1:0]      r_len, n_len;
    logic [ilpl_pkg::REGION_W-1:0]   r_region, n_region;
    logic                            r_have_hit, n_have_hit;
    logic [ilpl_pkg::LEN_W-1:0]      r_best_len, n_best_len;
    logic [ilpl_pkg::REGION_W-1:0]   r_found, n_found;
    logic                            r_slot_hit, n_slot_hit;
    logic [IDX_W-1:0]                r_slot_idx, n_slot_idx;
    logic                            r_out_vld, n_out_vld;
    logic [ilpl_pkg::REGION_W-1:0]   r_out_found, n_out_found;
    logic                            r_out_hit, n_out_hit;
    logic [ilpl_pkg::STATUS_W-1:0]   r_out_status, n_out_status;

    logic                            accept;
    logic                            rd_en;
    logic                            wr_en;
    logic [IDX_W-1:0]                wr_idx;
    ilpl_pkg::t_route                wr_data;
    ilpl_pkg::t_route                rd_data;
    ilpl_pkg::t_cmp_res              cmp_res;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign rd_en  = (r_state == S_SCAN);

    ilpl_route_mem #(
        .DEPTH (TABLE_ENTRIES),
        .IDX_W (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_idx  (wr_idx),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_idx  (r_rd_idx),
        .o_rd_data (rd_data)
    );

    // Shared comparator: one table entry per cycle.
    ilpl_match_unit u_match (
        .i_is_lookup (r_is_lookup),
        .i_target    (r_target),
        .i_entry     (rd_data),
        .i_have_hit  (r_have_hit),
        .i_best_len  (r_best_len),
        .o_res       (cmp_res)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_rd_idx     = r_rd_idx;
        n_cmp_vld    = r_cmp_vld;
        n_cmp_idx    = r_cmp_idx;
        n_is_lookup  = r_is_lookup;
        n_target     = r_target;
        n_len        = r_len;
        n_region     = r_region;
        n_have_hit   = r_have_hit;
        n_best_len   = r_best_len;
        n_found      = r_found;
        n_slot_hit   = r_slot_hit;
        n_slot_idx   = r_slot_idx;
        n_out_vld    = 1'b0;
        n_out_found  = r_out_found;
        n_out_hit    = r_out_hit;
        n_out_status = r_out_status;
        wr_en        = 1'b0;
        wr_idx       = r_slot_idx;
        wr_data.key    = r_target;
        wr_data.len    = r_len;
        wr_data.region = r_region;

        // Fold in the entry read on the previous cycle.
        if (r_cmp_vld) begin
            if (r_is_lookup) begin
                if (cmp_res.take_lookup) begin
                    n_have_hit = 1'b1;
                    n_best_len = rd_data.len;
                    n_found    = rd_data.region;
                end
            end else if (cmp_res.key_match && !r_slot_hit) begin
                n_slot_hit = 1'b1;
                n_slot_idx = r_cmp_idx;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_is_lookup = (i_req_type == ilpl_pkg::REQ_LOOKUP);
                    // Inserts carry the masked key; lookups carry the raw target.
                    n_target    = n_is_lookup ? i_address
                                              : (i_address & ilpl_pkg::net_mask(i_prefix_len));
                    n_len       = i_prefix_len;
                    n_region    = i_region_id;
                    n_have_hit  = 1'b0;
                    n_best_len  = '0;
                    n_found     = '0;
                    n_slot_hit  = 1'b0;
                    n_rd_idx    = '0;
                    n_cmp_vld   = 1'b0;
                    if (!n_is_lookup && (i_address == '0)) begin
                        // Skip zero-address inserts at once.
                        n_out_vld    = 1'b1;
                        n_out_found  = '0;
                        n_out_hit    = 1'b0;
                        n_out_status = ilpl_pkg::ST_SKIPPED;
                    end else if (r_count == '0) begin
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // Issue one read per cycle; compare lands on the next cycle.
                n_cmp_vld = 1'b1;
                n_cmp_idx = r_rd_idx;
                if (CNT_W'(r_rd_idx) == (r_count - CNT_W'(1))) begin
                    n_state = S_LAST;
                end else begin
                    n_rd_idx = r_rd_idx + IDX_W'(1);
                end
            end
            S_LAST: begin
                // Last entry compares this cycle.
                n_cmp_vld = 1'b0;
                n_state   = S_FINISH;
            end
            S_FINISH: begin
                n_out_vld = 1'b1;
                n_state   = S_IDLE;
                if (r_is_lookup) begin
                    n_out_found  = r_found;
                    n_out_hit    = r_have_hit;
                    n_out_status = ilpl_pkg::ST_STORED;
                end else begin
                    n_out_found = '0;
                    n_out_hit   = 1'b0;
                    if (r_slot_hit) begin
                        // Overwrite the existing key whatever its length.
                        wr_en        = 1'b1;
                        wr_idx       = r_slot_idx;
                        n_out_status = ilpl_pkg::ST_STORED;
                    end else if (r_count < CNT_MAX) begin
                        // Take the lowest free slot and extend the fill.
                        wr_en        = 1'b1;
                        wr_idx       = r_count[IDX_W-1:0];
                        n_count      = r_count + CNT_W'(1);
                        n_out_status = ilpl_pkg::ST_STORED;
                    end else begin
                        n_out_status = ilpl_pkg::ST_FULL;
                    end
                end
            end
            default: begin
                n_state   = S_IDLE;
                n_cmp_vld = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_cmp_vld <= n_cmp_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx     <= n_rd_idx;
        r_cmp_idx    <= n_cmp_idx;
        r_is_lookup  <= n_is_lookup;
        r_target     <= n_target;
        r_len        <= n_len;
        r_region     <= n_region;
        r_have_hit   <= n_have_hit;
        r_best_len   <= n_best_len;
        r_found      <= n_found;
        r_slot_hit   <= n_slot_hit;
        r_slot_idx   <= n_slot_idx;
        r_out_found  <= n_out_found;
        r_out_hit    <= n_out_hit;
        r_out_status <= n_out_status;
    end

    assign o_result_valid  = r_out_vld;
    assign o_found_id      = r_out_found;
    assign o_hit           = r_out_hit;
    assign o_insert_status = r_out_status;

    `ILPL_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_MAX, "fill count overflow")
    `ILPL_ASSERT_IMP(a_scan_in_fill, i_clk, i_rst_n, r_state == S_SCAN, CNT_W'(r_rd_idx) < r_count, "scan past fill")
    `ILPL_ASSERT_NXT(a_accept_moves, i_clk, i_rst_n, start && !busy, busy || o_result_valid, "request lost")
    `ILPL_ASSERT_IMP(a_hit_no_status, i_clk, i_rst_n, o_result_valid && o_hit, o_insert_status == ilpl_pkg::ST_STORED, "hit with insert status")

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

// Route table lookup bench: directed rows first, then random inserts and lookups.
// A shadow route table predicts every result, and each strobed result is checked
// against the oldest pending prediction.
module tb;
    import ilpl_pkg::*;

    localparam int TABLE_ENTRIES = 64;
    localparam int N_RANDOM      = 480;
    localparam int CALM_TAIL     = 60;          // final stretch of requests with no idling
    localparam int DRAIN_CYCLES  = TABLE_ENTRIES + 10;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [REGION_W-1:0] found_id;
        logic                hit;
        logic [STATUS_W-1:0] status;
    } route_result_t;

    typedef struct packed {
        logic                req_type;
        logic [ADDR_W-1:0]   address;
        logic [LEN_W-1:0]    prefix_len;
        logic [REGION_W-1:0] region_id;
        logic                typed;      // result below is given, not predicted
        route_result_t       result;
    } directed_row_t;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  prefix_len;
    } pool_route_t;

    // Directed rows. Typed results are the obvious ones: empty-table misses, the
    // zero-address skip and plain stores. Lookups against nested routes go to the
    // shadow table.
    localparam directed_row_t DIRECTED_ROWS [26] = '{
        // lookups on an empty table, at both address extremes
        '{REQ_LOOKUP, 32'hFFFF_FFFF, 6'd0,  32'h0000_0000, 1'b1, '{32'd0, 1'b0, ST_STORED}},
        '{REQ_LOOKUP, 32'h0000_0000, 6'd32, 32'h0000_0000, 1'b1, '{32'd0, 1'b0, ST_STORED}},
        // zero address on insert: skipped
        '{REQ_INSERT, 32'h0000_0000, 6'd24, 32'hDEAD_BEEF, 1'b1, '{32'd0, 1'b0, ST_SKIPPED}},
        // three nested routes
        '{REQ_INSERT, 32'h0A00_0000, 6'd8,  32'h0000_0011, 1'b1, '{32'd0, 1'b0, ST_STORED}},
        '{REQ_INSERT, 32'h0A01_0000, 6'd16, 32'h0000_0022, 1'b1, '{32'd0, 1'b0, ST_STORED}},
        '{REQ_INSERT, 32'h0A01_0200, 6'd24, 32'h0000_0033, 1'b1, '{32'd0, 1'b0, ST_STORED}},
        '{REQ_LOOKUP, 32'h0A01_0203, 6'd0,  32'h0000_0000, 1'b0, '0},
        '{REQ_LOOKUP, 32'h0A01_FF01, 6'd0,  32'h0000_0000, 1'b0, '0},
        '{REQ_LOOKUP, 32'h0AFF_FFFF, 6'd0,  32'h0000_0000, 1'b0, '0},
        // host route at the top of the address space, all-ones region
        '{REQ_INSERT, 32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF, 1'b1, '{32'd0, 1'b0, ST_STORED}},
        '{REQ_LOOKUP, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 1'b0, '0},
        // length zero: stored with key zero, never matches
        '{REQ_INSERT, 32'hC0A8_0000, 6'd0,  32'h0000_0044, 1'b1, '{32'd0, 1'b0, ST_STORED}},
        // length below the lookup minimum: stored, never matches
        '{REQ_INSERT, 32'hAC10_0000, 6'd6,  32'h0000_0055, 1'b1, '{32'd0, 1'b0, ST_STORED}},
        '{REQ_LOOKUP, 32'hAC10_0001, 6'd0,  32'h0000_0000, 1'b0, '0},
        // length above 32: full mask, raw length kept, never matches
        '{REQ_INSERT, 32'h8000_0001, 6'd63, 32'h0000_0066, 1'b1, '{32'd0, 1'b0, ST_STORED}},
        '{REQ_LOOKUP, 32'h8000_0001, 6'd0,  32'h0000_0000, 1'b0, '0},
        // /7 masks onto the existing /8 key: overwrite, and a region-zero hit
        '{REQ_INSERT, 32'h0B00_0000, 6'd7,  32'h0000_0000, 1'b1, '{32'd0, 1'b0, ST_STORED}},
        '{REQ_LOOKUP, 32'h0BFF_FFFF, 6'd0,  32'h0000_0000, 1'b0, '0},
        // deeper route inside the /24
        '{REQ_INSERT, 32'h0A01_0280, 6'd25, 32'h0000_0077, 1'b1, '{32'd0, 1'b0, ST_STORED}},
        '{REQ_LOOKUP, 32'h0A01_02FF, 6'd0,  32'h0000_0000, 1'b0, '0},
        // same key again: overwrite the region
        '{REQ_INSERT, 32'h0A01_0200, 6'd24, 32'h0000_0088, 1'b1, '{32'd0, 1'b0, ST_STORED}},
        '{REQ_LOOKUP, 32'h0A01_0201, 6'd0,  32'h0000_0000, 1'b0, '0},
        // length 33 entry, then the same key at /32 brings it back into play
        '{REQ_INSERT, 32'h7FFF_FFFF, 6'd33, 32'h1234_5678, 1'b1, '{32'd0, 1'b0, ST_STORED}},
        '{REQ_LOOKUP, 32'h7FFF_FFFF, 6'd0,  32'h0000_0000, 1'b0, '0},
        '{REQ_INSERT, 32'h7FFF_FFFF, 6'd32, 32'h9ABC_DEF0, 1'b1, '{32'd0, 1'b0, ST_STORED}},
        '{REQ_LOOKUP, 32'h7FFF_FFFF, 6'd0,  32'h0000_0000, 1'b0, '0}
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic                i_req_type;
    logic [ADDR_W-1:0]   i_address;
    logic [LEN_W-1:0]    i_prefix_len;
    logic [REGION_W-1:0] i_region_id;
    logic                o_result_valid;
    logic [REGION_W-1:0] o_found_id;
    logic                o_hit;
    logic [STATUS_W-1:0] o_insert_status;

    // Shadow route table. Only entries marked used are ever read.
    logic [ADDR_W-1:0]   shadow_key    [TABLE_ENTRIES];
    logic [LEN_W-1:0]    shadow_len    [TABLE_ENTRIES];
    logic [REGION_W-1:0] shadow_region [TABLE_ENTRIES];
    bit                  shadow_used   [TABLE_ENTRIES];

    route_result_t pending_results[$];  // predicted results, oldest first
    route_result_t head_result;
    pool_route_t   route_pool[$];       // routes inserted so far, used to aim lookups
    int            mismatch_count = 0;

    ipv4_longest_prefix_lookup #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_address      (i_address),
        .i_prefix_len   (i_prefix_len),
        .i_region_id    (i_region_id),
        .o_result_valid (o_result_valid),
        .o_found_id     (o_found_id),
        .o_hit          (o_hit),
        .o_insert_status(o_insert_status)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Netmask for a prefix length; anything at or above 32 keeps every bit.
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] plen);
        if (plen == '0) begin
            return '0;
        end
        if (plen >= LEN_W'(ADDR_W)) begin
            return '1;
        end
        return ~({ADDR_W{1'b1}} >> plen);
    endfunction

    // Apply one request to the shadow table and return the result it must give.
    function automatic route_result_t predict_route_request(
        input logic                rtype,
        input logic [ADDR_W-1:0]   addr,
        input logic [LEN_W-1:0]    plen,
        input logic [REGION_W-1:0] region
    );
        route_result_t     res;
        logic [ADDR_W-1:0] key;
        logic [LEN_W-1:0]  best_len;
        int                slot;
        int                free_slot;
        res       = '{found_id: '0, hit: 1'b0, status: ST_STORED};
        best_len  = '0;
        slot      = -1;
        free_slot = -1;
        if (rtype == REQ_LOOKUP) begin
            // Walk every live route; keep the strictly longest usable match.
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (shadow_used[i] && shadow_len[i] >= LEN_W'(MIN_LOOKUP_LEN)
                        && shadow_len[i] <= LEN_W'(ADDR_W)
                        && (addr & prefix_mask(shadow_len[i])) == shadow_key[i]
                        && (!res.hit || shadow_len[i] > best_len)) begin
                    best_len     = shadow_len[i];
                    res.found_id = shadow_region[i];
                    res.hit      = 1'b1;
                end
            end
        end else if (addr == '0) begin
            res.status = ST_SKIPPED;
        end else begin
            key = addr & prefix_mask(plen);
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (shadow_used[i]) begin
                    if (slot < 0 && shadow_key[i] == key) begin
                        slot = i;
                    end
                end else if (free_slot < 0) begin
                    free_slot = i;
                end
            end
            if (slot < 0) begin
                slot = free_slot;
            end
            if (slot < 0) begin
                res.status = ST_FULL;
            end else begin
                shadow_key[slot]    = key;
                shadow_len[slot]    = plen;
                shadow_region[slot] = region;
                shadow_used[slot]   = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: %s", $time, msg);
        end
    endfunction

    // Present one request and hold it until the block takes it, then record the
    // result it must produce. Start stays high afterwards; the next call or an
    // idle burst decides what happens to it.
    task automatic issue_request(
        input logic                rtype,
        input logic [ADDR_W-1:0]   addr,
        input logic [LEN_W-1:0]    plen,
        input logic [REGION_W-1:0] region,
        input logic                typed,
        input route_result_t       typed_result
    );
        route_result_t predicted;
        start        <= 1'b1;
        i_req_type   <= rtype;
        i_address    <= addr;
        i_prefix_len <= plen;
        i_region_id  <= region;
        // Busy is sampled before this edge updates it: a low value means taken.
        do begin
            @(posedge i_clk);
        end while (busy);
        predicted = predict_route_request(rtype, addr, plen, region);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    // Drop start for a burst of idle cycles.
    task automatic idle_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Hold off new requests until every predicted result has come back.
    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Result checker: the receiver cannot stall, so every strobe is consumed.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (pending_results.size() == 0) begin
                note_mismatch($sformatf("unexpected result: found_id %h hit %b status %0d",
                                        o_found_id, o_hit, o_insert_status));
            end else begin
                head_result = pending_results.pop_front();
                if (o_found_id !== head_result.found_id || o_hit !== head_result.hit
                        || o_insert_status !== head_result.status) begin
                    note_mismatch($sformatf(
                        "mismatch: expected found_id %h hit %b status %0d, got %h %b %0d",
                        head_result.found_id, head_result.hit, head_result.status,
                        o_found_id, o_hit, o_insert_status));
                end
            end
        end
    end

    // Stimulus
    initial begin
        logic [7:0]          bases [4];
        logic                rtype;
        logic [ADDR_W-1:0]   addr;
        logic [ADDR_W-1:0]   mask;
        logic [LEN_W-1:0]    plen;
        logic [REGION_W-1:0] region;
        pool_route_t         pick;
        int                  roll;
        bit                  idle_phase;

        // Drive every input to a known value before the first edge.
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_req_type   <= REQ_INSERT;
        i_address    <= '0;
        i_prefix_len <= '0;
        i_region_id  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows, with the odd idle burst between them.
        foreach (DIRECTED_ROWS[r]) begin
            issue_request(DIRECTED_ROWS[r].req_type, DIRECTED_ROWS[r].address,
                          DIRECTED_ROWS[r].prefix_len, DIRECTED_ROWS[r].region_id,
                          DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].result);
            if ($urandom_range(0, 2) == 0) begin
                idle_sender($urandom_range(1, 19));
            end
        end
        drain_results();

        // A few top bytes shared by most new routes, so prefixes nest and collide.
        foreach (bases[b]) begin
            bases[b] = 8'($urandom);
        end

        // Random part. The table fills partway through; after that, new keys
        // come back full while overwrites of existing keys still land.
        for (int k = 0; k < N_RANDOM; k++) begin
            roll   = $urandom_range(0, 99);
            region = $urandom;
            if ($urandom_range(0, 15) == 0) begin
                region = '0;
            end
            plen = LEN_W'($urandom);
            if (roll < 45) begin
                // lookup: mostly aimed under a known route, else anywhere
                rtype = REQ_LOOKUP;
                if (route_pool.size() != 0 && roll < 32) begin
                    pick = route_pool[$urandom_range(0, route_pool.size() - 1)];
                    mask = prefix_mask(pick.prefix_len);
                    addr = (pick.address & mask) | (ADDR_W'($urandom) & ~mask);
                end else if (roll < 38) begin
                    addr = {bases[$urandom_range(0, 3)], 24'($urandom)};
                end else begin
                    addr = $urandom;
                end
            end else if (roll < 55 && route_pool.size() != 0) begin
                // re-insert a known network: same key overwrites, new length may not
                rtype = REQ_INSERT;
                pick  = route_pool[$urandom_range(0, route_pool.size() - 1)];
                mask  = prefix_mask(pick.prefix_len);
                addr  = (pick.address & mask) | (ADDR_W'($urandom) & ~mask);
                plen  = (roll < 50) ? pick.prefix_len : LEN_W'($urandom_range(7, 32));
                route_pool.push_back('{address: addr, prefix_len: plen});
            end else if (roll < 60) begin
                // odd inserts: zero address, zero length, short and oversized lengths
                rtype = REQ_INSERT;
                addr  = $urandom;
                case ($urandom_range(0, 3))
                    0: begin
                        addr = '0;
                    end
                    1: begin
                        plen = '0;
                    end
                    2: begin
                        plen = LEN_W'($urandom_range(1, MIN_LOOKUP_LEN - 1));
                    end
                    default: begin
                        plen = LEN_W'($urandom_range(ADDR_W + 1, (1 << LEN_W) - 1));
                    end
                endcase
            end else begin
                // new route under one of the shared top bytes
                rtype = REQ_INSERT;
                addr  = {bases[$urandom_range(0, 3)], 24'($urandom)};
                plen  = LEN_W'($urandom_range(MIN_LOOKUP_LEN, ADDR_W));
                route_pool.push_back('{address: addr, prefix_len: plen});
            end

            issue_request(rtype, addr, plen, region, 1'b0, '0);

            // Hold off once midway until the block has answered everything.
            if (k == N_RANDOM / 2) begin
                drain_results();
            end

            // Idle in alternating stretches of 40 requests; none in the calm tail.
            idle_phase = ((k / 40) % 2) == 0;
            if (k < N_RANDOM - CALM_TAIL && idle_phase && $urandom_range(0, 2) == 0) begin
                idle_sender($urandom_range(1, 19));
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    // Watchdog: the slowest legal run is far below this.
    initial begin
        #20_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
